// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int ROOT_FRAC_DEF  = 16;
    localparam int ROOT_W         = 32;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_INF  = 2'd3
    } t_root_class;

endpackage

// ===== rtl/qrs_front.sv =====
module qrs_front #(
    parameter int W = qrs_pkg::COEF_WIDTH_DEF,
    parameter int F = qrs_pkg::ROOT_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [W-1:0]                i_a,
    input  logic [W-1:0]                i_b,
    input  logic [W-1:0]                i_c,
    output logic                        o_vld,
    output qrs_pkg::t_root_class        o_cls,
    output logic                        o_an,
    output logic                        o_bn,
    output logic                        o_cn,
    output logic [W-1:0]                o_am,
    output logic [W-1:0]                o_bm,
    output logic [W-1:0]                o_cm,
    output logic [2*W+2+2*F-1:0]        o_rad
);
    localparam int DW = 2*W+2;

    logic         r_v1, r_an, r_bn, r_cn;
    logic [W-1:0] r_am, r_bm, r_cm;
    logic [2*W-1:0] r_b2, r_ac;
    logic [W-1:0] n_am, n_bm, n_cm;

    logic          r_v2, r_an2, r_bn2, r_cn2;
    logic [W-1:0]  r_am2, r_bm2, r_cm2;
    logic [DW-1:0] r_d;
    qrs_pkg::t_root_class r_cls;

    logic [DW-1:0] four_ac, b2x, n_d;
    logic          mixed, d_ok;
    qrs_pkg::t_root_class n_cls;

    always_comb begin
        n_am = i_a[W-1] ? (~i_a + W'(1)) : i_a;
        n_bm = i_b[W-1] ? (~i_b + W'(1)) : i_b;
        n_cm = i_c[W-1] ? (~i_c + W'(1)) : i_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_an <= i_a[W-1];
        r_bn <= i_b[W-1];
        r_cn <= i_c[W-1];
        r_am <= n_am;
        r_bm <= n_bm;
        r_cm <= n_cm;
        r_b2 <= n_bm * n_bm;
        r_ac <= n_am * n_cm;
    end

    always_comb begin
        four_ac = {r_ac, 2'b00};
        b2x     = DW'(r_b2);
        mixed   = (r_an != r_cn) && (r_ac != '0);
        d_ok    = 1'b1;
        n_d     = '0;
        if (mixed) begin
            n_d = b2x + four_ac;
        end else if (four_ac > b2x) begin
            d_ok = 1'b0;
        end else begin
            n_d = b2x - four_ac;
        end
        if (r_am == '0) begin
            if (r_bm == '0) begin
                n_cls = (r_cm == '0) ? qrs_pkg::CLS_INF : qrs_pkg::CLS_NONE;
            end else begin
                n_cls = qrs_pkg::CLS_ONE;
            end
        end else begin
            n_cls = d_ok ? qrs_pkg::CLS_TWO : qrs_pkg::CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_an2 <= r_an;
        r_bn2 <= r_bn;
        r_cn2 <= r_cn;
        r_am2 <= r_am;
        r_bm2 <= r_bm;
        r_cm2 <= r_cm;
        r_d   <= n_d;
        r_cls <= n_cls;
    end

    assign o_vld = r_v2;
    assign o_cls = r_cls;
    assign o_an  = r_an2;
    assign o_bn  = r_bn2;
    assign o_cn  = r_cn2;
    assign o_am  = r_am2;
    assign o_bm  = r_bm2;
    assign o_cm  = r_cm2;
    assign o_rad = {r_d, {(2*F){1'b0}}};

endmodule

// ===== rtl/qrs_sqrt_cell.sv =====
module qrs_sqrt_cell #(
    parameter int RW     = 66,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [RW-1:0]     i_x,
    input  logic [RW/2-1:0]   i_root,
    input  logic [RW/2+1:0]   i_rem,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [RW-1:0]     o_x,
    output logic [RW/2-1:0]   o_root,
    output logic [RW/2+1:0]   o_rem,
    output logic [SIDE_W-1:0] o_side
);
    localparam int SW = RW/2;

    logic [SW+1:0] rem_sh, trial;
    logic          ge;

    always_comb begin
        rem_sh = {i_rem[SW-1:0], i_x[RW-1:RW-2]};
        trial  = {i_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_x    <= {i_x[RW-3:0], 2'b00};
        o_root <= {i_root[SW-2:0], ge};
        o_rem  <= ge ? (rem_sh - trial) : rem_sh;
        o_side <= i_side;
    end

endmodule

// ===== rtl/qrs_div_cell.sv =====
module qrs_div_cell #(
    parameter int NW     = 34,
    parameter int DV     = 17,
    parameter int SIDE_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NW-1:0]     i_n,
    input  logic [DV-1:0]     i_d,
    input  logic [DV-1:0]     i_rem,
    input  logic [NW-1:0]     i_q,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NW-1:0]     o_n,
    output logic [DV-1:0]     o_d,
    output logic [DV-1:0]     o_rem,
    output logic [NW-1:0]     o_q,
    output logic [SIDE_W-1:0] o_side
);
    logic [DV:0] r_sh, r_sub;
    logic        ge;

    always_comb begin
        r_sh  = {i_rem, i_n[NW-1]};
        ge    = r_sh >= {1'b0, i_d};
        r_sub = r_sh - {1'b0, i_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_n    <= {i_n[NW-2:0], 1'b0};
        o_d    <= i_d;
        o_rem  <= ge ? r_sub[DV-1:0] : r_sh[DV-1:0];
        o_q    <= {i_q[NW-2:0], ge};
        o_side <= i_side;
    end

endmodule

// ===== rtl/quadratic_root_solver_core.sv =====
// Pipelined quadratic solver: one coefficient set is taken every cycle (busy
// stays low); its result passes the front end, the square-root cell row, the
// numerator register, the two divider cell rows and the output register
// before it appears on o_strobe. SW = 2*COEF_WIDTH/2 + 1 + ROOT_FRAC_BITS
// is the length of the square-root cell row (one result bit per cell) and
// NW = COEF_WIDTH + ROOT_FRAC_BITS + 2 that of each divider cell row (one
// quotient bit per cell). Results are issued in order and the receiver
// cannot stall them, so it must take every strobe.
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH_DEF,
    parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_c,
    output logic                          o_strobe,
    output logic [1:0]                    o_root_class,
    output logic signed [qrs_pkg::ROOT_W-1:0] o_root_first,
    output logic signed [qrs_pkg::ROOT_W-1:0] o_root_second,
    output logic                          o_overflow
);
    localparam int W   = COEF_WIDTH;
    localparam int F   = ROOT_FRAC_BITS;
    localparam int RW  = 2*W + 2 + 2*F;
    localparam int SW  = RW/2;
    localparam int NW  = W + F + 2;
    localparam int NS  = NW + 1;
    localparam int DV  = W + 1;
    localparam int RO  = qrs_pkg::ROOT_W;
    localparam int QX  = (NW > RO + 1) ? NW : RO + 1;
    localparam int SQS = 5 + 3*W;
    localparam int D1S = 3;

    // front end
    logic                 f_vld, f_an, f_bn, f_cn;
    logic [W-1:0]         f_am, f_bm, f_cm;
    logic [RW-1:0]        f_rad;
    qrs_pkg::t_root_class f_cls;

    qrs_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_vld   (f_vld),
        .o_cls   (f_cls),
        .o_an    (f_an),
        .o_bn    (f_bn),
        .o_cn    (f_cn),
        .o_am    (f_am),
        .o_bm    (f_bm),
        .o_cm    (f_cm),
        .o_rad   (f_rad)
    );

    // square-root row
    logic            sq_vld  [0:SW];
    logic [RW-1:0]   sq_x    [0:SW];
    logic [SW-1:0]   sq_root [0:SW];
    logic [SW+1:0]   sq_rem  [0:SW];
    logic [SQS-1:0]  sq_side [0:SW];

    assign sq_vld[0]  = f_vld;
    assign sq_x[0]    = f_rad;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_side[0] = {f_cls, f_an, f_bn, f_cn, f_am, f_bm, f_cm};

    for (genvar gi = 0; gi < SW; gi++) begin : g_sqrt
        qrs_sqrt_cell #(.RW(RW), .SIDE_W(SQS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_vld[gi]),
            .i_x     (sq_x[gi]),
            .i_root  (sq_root[gi]),
            .i_rem   (sq_rem[gi]),
            .i_side  (sq_side[gi]),
            .o_vld   (sq_vld[gi+1]),
            .o_x     (sq_x[gi+1]),
            .o_root  (sq_root[gi+1]),
            .o_rem   (sq_rem[gi+1]),
            .o_side  (sq_side[gi+1])
        );
    end

    // numerator and divisor set-up
    logic [1:0]      s_cls;
    logic            s_an, s_bn, s_cn;
    logic [W-1:0]    s_am, s_bm, s_cm;
    logic [NS-1:0]   nb_mag, nb, n1s, n2s;
    logic [NW-1:0]   n_n1, n_n2;
    logic [DV-1:0]   n_d1, n_d2;
    logic            n_neg1, n_neg2;

    assign {s_cls, s_an, s_bn, s_cn, s_am, s_bm, s_cm} = sq_side[SW];

    always_comb begin
        nb_mag = NS'({s_bm, {F{1'b0}}});
        nb     = s_bn ? nb_mag : (~nb_mag + NS'(1));
        n1s    = nb - NS'(sq_root[SW]);
        n2s    = nb + NS'(sq_root[SW]);
        n_n2   = n2s[NS-1] ? NW'(~n2s + NS'(1)) : n2s[NW-1:0];
        n_d2   = {s_am, 1'b0};
        n_neg2 = n2s[NS-1] ^ s_an;
        if (s_cls == qrs_pkg::CLS_ONE) begin
            n_n1   = NW'({s_cm, {F{1'b0}}});
            n_d1   = DV'(s_bm);
            n_neg1 = (!s_cn && (s_cm != '0)) ^ s_bn;
        end else begin
            n_n1   = n1s[NS-1] ? NW'(~n1s + NS'(1)) : n1s[NW-1:0];
            n_d1   = {s_am, 1'b0};
            n_neg1 = n1s[NS-1] ^ s_an;
        end
    end

    logic            r_nv;
    logic [NW-1:0]   r_n1, r_n2;
    logic [DV-1:0]   r_d1, r_d2;
    logic            r_neg1, r_neg2;
    logic [1:0]      r_ncls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else begin
            r_nv <= sq_vld[SW];
        end
        r_n1   <= n_n1;
        r_n2   <= n_n2;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_neg1 <= n_neg1;
        r_neg2 <= n_neg2;
        r_ncls <= s_cls;
    end

    // divider rows
    logic            da_vld [0:NW];
    logic [NW-1:0]   da_n   [0:NW];
    logic [DV-1:0]   da_d   [0:NW];
    logic [DV-1:0]   da_rem [0:NW];
    logic [NW-1:0]   da_q   [0:NW];
    logic [D1S-1:0]  da_side[0:NW];
    logic            db_vld [0:NW];
    logic [NW-1:0]   db_n   [0:NW];
    logic [DV-1:0]   db_d   [0:NW];
    logic [DV-1:0]   db_rem [0:NW];
    logic [NW-1:0]   db_q   [0:NW];
    logic            db_side[0:NW];

    assign da_vld[0]  = r_nv;
    assign da_n[0]    = r_n1;
    assign da_d[0]    = r_d1;
    assign da_rem[0]  = '0;
    assign da_q[0]    = '0;
    assign da_side[0] = {r_ncls, r_neg1};
    assign db_vld[0]  = r_nv;
    assign db_n[0]    = r_n2;
    assign db_d[0]    = r_d2;
    assign db_rem[0]  = '0;
    assign db_q[0]    = '0;
    assign db_side[0] = r_neg2;

    for (genvar gj = 0; gj < NW; gj++) begin : g_div
        qrs_div_cell #(.NW(NW), .DV(DV), .SIDE_W(D1S)) u_cell_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (da_vld[gj]),
            .i_n     (da_n[gj]),
            .i_d     (da_d[gj]),
            .i_rem   (da_rem[gj]),
            .i_q     (da_q[gj]),
            .i_side  (da_side[gj]),
            .o_vld   (da_vld[gj+1]),
            .o_n     (da_n[gj+1]),
            .o_d     (da_d[gj+1]),
            .o_rem   (da_rem[gj+1]),
            .o_q     (da_q[gj+1]),
            .o_side  (da_side[gj+1])
        );
        qrs_div_cell #(.NW(NW), .DV(DV), .SIDE_W(1)) u_cell_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (db_vld[gj]),
            .i_n     (db_n[gj]),
            .i_d     (db_d[gj]),
            .i_rem   (db_rem[gj]),
            .i_q     (db_q[gj]),
            .i_side  (db_side[gj]),
            .o_vld   (db_vld[gj+1]),
            .o_n     (db_n[gj+1]),
            .o_d     (db_d[gj+1]),
            .o_rem   (db_rem[gj+1]),
            .o_q     (db_q[gj+1]),
            .o_side  (db_side[gj+1])
        );
    end

    // saturation and output register
    function automatic logic [RO:0] f_sat(input logic [QX-1:0] q, input logic neg);
        logic [QX-1:0] lim_neg, lim_pos;
        logic [RO:0]   res;
        lim_neg = QX'(1) << (RO - 1);
        lim_pos = lim_neg - QX'(1);
        if (neg && (q != '0)) begin
            if (q > lim_neg) begin
                res = {1'b1, lim_neg[RO-1:0]};
            end else begin
                res = {1'b0, ~q[RO-1:0] + RO'(1)};
            end
        end else if (q > lim_pos) begin
            res = {1'b1, lim_pos[RO-1:0]};
        end else begin
            res = {1'b0, q[RO-1:0]};
        end
        return res;
    endfunction

    logic [RO:0]          sat1, sat2;
    logic [1:0]           e_cls_bits;
    logic                 e_neg1;
    qrs_pkg::t_root_class e_cls;
    logic [RO-1:0]        n_r1, n_r2;
    logic                 n_ovf;

    logic                 r_strobe, r_ovf;
    logic [1:0]           r_cls;
    logic [RO-1:0]        r_r1, r_r2;

    assign {e_cls_bits, e_neg1} = da_side[NW];
    assign e_cls = qrs_pkg::t_root_class'(e_cls_bits);

    always_comb begin
        sat1  = f_sat(QX'(da_q[NW]), e_neg1);
        sat2  = f_sat(QX'(db_q[NW]), db_side[NW]);
        n_r1  = '0;
        n_r2  = '0;
        n_ovf = 1'b0;
        case (e_cls)
            qrs_pkg::CLS_ONE: begin
                n_r1  = sat1[RO-1:0];
                n_ovf = sat1[RO];
            end
            qrs_pkg::CLS_TWO: begin
                n_r1  = sat1[RO-1:0];
                n_r2  = sat2[RO-1:0];
                n_ovf = sat1[RO] | sat2[RO];
            end
            default: begin
                n_r1  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= da_vld[NW] & db_vld[NW];
        end
        r_cls <= e_cls_bits;
        r_r1  <= n_r1;
        r_r2  <= n_r2;
        r_ovf <= n_ovf;
    end

    assign busy          = 1'b0;
    assign o_strobe      = r_strobe;
    assign o_root_class  = r_cls;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_overflow    = r_ovf;

endmodule

// ===== rtl/qrs_checker.sv =====
module qrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_root_class,
    input logic [31:0] o_root_first,
    input logic [31:0] o_root_second,
    input logic        o_overflow
);
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_root_class == qrs_pkg::CLS_NONE || o_root_class == qrs_pkg::CLS_INF)
        |-> (o_root_first == '0) && (o_root_second == '0) && !o_overflow)
        else $error("roots set without a root");

    a_lin_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_root_class == qrs_pkg::CLS_ONE) |-> (o_root_second == '0))
        else $error("second root set for linear case");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_root_class  (o_root_class),
    .o_root_first  (o_root_first),
    .o_root_second (o_root_second),
    .o_overflow    (o_overflow)
);
